// ----- rtl/core/ipv4_lpm_pkg.sv -----
// Shared types, operation codes and helpers for the IPv4 longest-prefix-match table.
package ipv4_lpm_pkg;

    localparam logic [1:0] FN_QUERY  = 2'd0;
    localparam logic [1:0] FN_INSERT = 2'd1;
    localparam logic [1:0] FN_DELETE = 2'd2;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [5:0]  MAX_LEN  = 6'd32;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic scan_issue;
        logic commit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic cnt_last;
    } sts_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] prefix;
        logic [5:0]  length;
        logic [7:0]  port;
        logic [31:0] next_hop;
    } slot_t;

    // Network mask with the top len bits set; len is 0..32
    function automatic logic [31:0] len_mask(input logic [5:0] len);
        logic [31:0] m;
        if (len == 6'd0) begin
            m = '0;
        end else if (len >= MAX_LEN) begin
            m = ALL_ONES;
        end else begin
            m = ~(ALL_ONES >> len);
        end
        return m;
    endfunction

endpackage

// ----- rtl/core/ipv4_lpm_ctrl.sv -----
// Controller state machine: clearing pass, request capture, table scan and result hand-off.
module ipv4_lpm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  ipv4_lpm_pkg::sts_t  sts,
    output ipv4_lpm_pkg::cmd_t  cmd
);
    import ipv4_lpm_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sts.cnt_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (sts.cnt_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        cmd            = '0;
        s_ready        = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
            end
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_SCAN: begin
                cmd.scan_issue = 1'b1;
            end
            ST_COMMIT: begin
                cmd.commit = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // Hold the result until taken; a commit refills the output register
    always_comb begin
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- rtl/core/ipv4_lpm_dp.sv -----
// Datapath: slot memory, scan counter, match accumulators and result register.
module ipv4_lpm_dp #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ipv4_lpm_pkg::cmd_t  cmd,
    output ipv4_lpm_pkg::sts_t  sts,
    input  logic [1:0]          s_func,
    input  logic [31:0]         s_address,
    input  logic [5:0]          s_prefix_len,
    input  logic [7:0]          s_port,
    input  logic [31:0]         s_next_hop,
    output logic                m_found,
    output logic [31:0]         m_next_hop_out,
    output logic [7:0]          m_port_out,
    output logic                m_table_full
);
    import ipv4_lpm_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    slot_t mem [TABLE_ENTRIES];

    logic [1:0]       func_reg;
    logic [31:0]      addr_reg;
    logic [5:0]       len_reg;
    logic [7:0]       port_reg;
    logic [31:0]      nh_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    slot_t            rd_data_reg;

    logic             best_hit_reg;
    logic [5:0]       best_len_reg;
    logic [7:0]       best_port_reg;
    logic [31:0]      best_nh_reg;
    logic             exact_hit_reg;
    logic [IDX_W-1:0] exact_idx_reg;
    logic             free_hit_reg;
    logic [IDX_W-1:0] free_idx_reg;

    logic             found_reg;
    logic [31:0]      nh_out_reg;
    logic [7:0]       port_out_reg;
    logic             full_reg;

    logic [5:0]       len_sat;
    logic [31:0]      key_prefix;
    logic             hit_lpm;
    logic             hit_better;
    logic             hit_exact;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_t            wr_data;
    logic             res_found;

    assign len_sat    = (s_prefix_len > MAX_LEN) ? MAX_LEN : s_prefix_len;
    assign key_prefix = addr_reg & len_mask(len_reg);

    assign hit_lpm    = rd_data_reg.valid &&
                        (((addr_reg ^ rd_data_reg.prefix) & len_mask(rd_data_reg.length)) == '0);
    assign hit_better = !best_hit_reg || (rd_data_reg.length > best_len_reg);
    assign hit_exact  = rd_data_reg.valid && (rd_data_reg.length == len_reg) &&
                        (rd_data_reg.prefix == key_prefix);

    assign sts.cnt_last = (cnt_reg == IDX_W'(TABLE_ENTRIES - 1));

    // Capture the request
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg <= s_func;
            addr_reg <= s_address;
            len_reg  <= len_sat;
            port_reg <= s_port;
            nh_reg   <= s_next_hop;
        end
    end

    // Scan counter and read pipeline tag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.scan_issue;
            if (cmd.capture) begin
                cnt_reg <= '0;
            end else if (cmd.clear_wr || cmd.scan_issue) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= cnt_reg;
    end

    // Accumulate the longest match, the exact slot and the first free slot
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.capture) begin
            best_hit_reg  <= 1'b0;
            exact_hit_reg <= 1'b0;
            free_hit_reg  <= 1'b0;
        end else if (rd_vld_reg) begin
            if (hit_lpm && hit_better) begin
                best_hit_reg  <= 1'b1;
                best_len_reg  <= rd_data_reg.length;
                best_port_reg <= rd_data_reg.port;
                best_nh_reg   <= rd_data_reg.next_hop;
            end
            if (hit_exact && !exact_hit_reg) begin
                exact_hit_reg <= 1'b1;
                exact_idx_reg <= rd_idx_reg;
            end
            if (!rd_data_reg.valid && !free_hit_reg) begin
                free_hit_reg <= 1'b1;
                free_idx_reg <= rd_idx_reg;
            end
        end
    end

    // Single write port: clearing pass, insert or delete
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg;
        wr_data = '0;
        if (cmd.clear_wr) begin
            wr_en = 1'b1;
        end else if (cmd.commit) begin
            if (func_reg == FN_INSERT && (exact_hit_reg || free_hit_reg)) begin
                wr_en            = 1'b1;
                wr_addr          = exact_hit_reg ? exact_idx_reg : free_idx_reg;
                wr_data.valid    = 1'b1;
                wr_data.prefix   = key_prefix;
                wr_data.length   = len_reg;
                wr_data.port     = port_reg;
                wr_data.next_hop = nh_reg;
            end else if (func_reg == FN_DELETE && exact_hit_reg) begin
                wr_en   = 1'b1;
                wr_addr = exact_idx_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[cnt_reg];
    end

    assign res_found = (func_reg == FN_QUERY) && best_hit_reg;

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            found_reg    <= res_found;
            nh_out_reg   <= res_found ? best_nh_reg : '0;
            port_out_reg <= res_found ? best_port_reg : '0;
            full_reg     <= (func_reg == FN_INSERT) && !exact_hit_reg && !free_hit_reg;
        end
    end

    assign m_found        = found_reg;
    assign m_next_hop_out = nh_out_reg;
    assign m_port_out     = port_out_reg;
    assign m_table_full   = full_reg;

endmodule

// ----- rtl/core/ipv4_route_table_lpm.sv -----
// Top level of the IPv4 routing table with longest-prefix-match lookup.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------------
//  request  | in        | s_valid / s_ready  | s_func s_address s_prefix_len s_port s_next_hop
//  result   | out       | m_valid / m_ready  | m_found m_next_hop_out m_port_out m_table_full
//
// Each request is scanned one slot per cycle through the single read port; the last
// registered read then reaches the accumulators and the commit fills the result
// register; s_ready returns the cycle after the commit. After reset a clearing pass
// zeroes every slot; s_ready stays low meanwhile. The result waits in an output
// register, so the next request is accepted while it is still unclaimed; a stalled
// result only holds the commit step.
module ipv4_route_table_lpm #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [31:0] s_address,
    input  logic [5:0]  s_prefix_len,
    input  logic [7:0]  s_port,
    input  logic [31:0] s_next_hop,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [31:0] m_next_hop_out,
    output logic [7:0]  m_port_out,
    output logic        m_table_full
);
    import ipv4_lpm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequence the clearing pass, the scan of each request and the hand-off
    ipv4_lpm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Hold the slots, compare one per cycle and register the result
    ipv4_lpm_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_func         (s_func),
        .s_address      (s_address),
        .s_prefix_len   (s_prefix_len),
        .s_port         (s_port),
        .s_next_hop     (s_next_hop),
        .m_found        (m_found),
        .m_next_hop_out (m_next_hop_out),
        .m_port_out     (m_port_out),
        .m_table_full   (m_table_full)
    );

endmodule

// ----- rtl/core/ipv4_lpm_chk.sv -----
// Port-level checker for the routing table, bound to the top level.
module ipv4_lpm_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_found,
    input logic [31:0] m_next_hop_out,
    input logic [7:0]  m_port_out,
    input logic        m_table_full
);

    // One request at a time: ready drops after an acceptance
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while a scan was starting");

    // Stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_found) &&
            $stable(m_next_hop_out) && $stable(m_port_out) && $stable(m_table_full)))
        else $error("result changed while stalled");

    // A rejected insert never reports a match
    a_full_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_table_full) |-> !m_found)
        else $error("table_full together with found");

    // No match gives zero port and next hop
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_next_hop_out == 32'd0 && m_port_out == 8'd0))
        else $error("non-zero route data without a match");

endmodule

bind ipv4_route_table_lpm ipv4_lpm_chk u_chk (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_found        (m_found),
    .m_next_hop_out (m_next_hop_out),
    .m_port_out     (m_port_out),
    .m_table_full   (m_table_full)
);

// ----- tb/lpm_route_check_pkg.sv -----
`timescale 1ns / 100ps
// Route table predictor and result checker for the longest-prefix-match testbench.
package lpm_route_check_pkg;
    import ipv4_lpm_pkg::*;

    localparam int         ROUTE_SLOTS = 64;
    localparam logic [1:0] FN_UNUSED   = 2'd3;
    localparam int         REPORT_MAX  = 10;

    typedef struct packed {
        logic        found;
        logic [31:0] next_hop;
        logic [7:0]  port;
        logic        table_full;
    } lpm_result_t;

    // Top len bits set; any length of 32 or more gives a full mask.
    function automatic logic [31:0] route_mask(input logic [5:0] len);
        logic [31:0] m;
        for (int b = 0; b < 32; b++) begin
            m[31 - b] = (b < len);
        end
        return m;
    endfunction

    class route_lookup_checker;
        slot_t       routes[ROUTE_SLOTS];
        lpm_result_t pending_results[$];
        int          errors;

        function new();
            foreach (routes[i]) begin
                routes[i] = '0;
            end
            errors = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= REPORT_MAX) begin
                $display("%0t ns: mismatch: %s", $time, msg);
            end
        endfunction

        function int find_route(logic [31:0] pfx, logic [5:0] len);
            for (int i = 0; i < ROUTE_SLOTS; i++) begin
                if (routes[i].valid && routes[i].length == len && routes[i].prefix == pfx) begin
                    return i;
                end
            end
            return -1;
        endfunction

        // Apply one accepted request to the table copy and queue its result.
        function void note_request(logic [1:0] func, logic [31:0] addr, logic [5:0] len,
                                   logic [7:0] port, logic [31:0] nh);
            lpm_result_t res;
            logic [5:0]  plen;
            logic [31:0] pfx;
            int          hit;
            res  = '0;
            plen = (len > MAX_LEN) ? MAX_LEN : len;
            pfx  = addr & route_mask(plen);
            case (func)
                FN_QUERY: begin
                    hit = -1;
                    for (int i = 0; i < ROUTE_SLOTS; i++) begin
                        if (routes[i].valid &&
                            ((addr ^ routes[i].prefix) & route_mask(routes[i].length)) == '0 &&
                            (hit < 0 || routes[i].length > routes[hit].length)) begin
                            hit = i;
                        end
                    end
                    if (hit >= 0) begin
                        res.found    = 1'b1;
                        res.next_hop = routes[hit].next_hop;
                        res.port     = routes[hit].port;
                    end
                end
                FN_INSERT: begin
                    hit = find_route(pfx, plen);
                    for (int i = 0; i < ROUTE_SLOTS && hit < 0; i++) begin
                        if (!routes[i].valid) begin
                            hit = i;
                        end
                    end
                    if (hit < 0) begin
                        res.table_full = 1'b1;
                    end else begin
                        routes[hit] = '{valid: 1'b1, prefix: pfx, length: plen,
                                        port: port, next_hop: nh};
                    end
                end
                FN_DELETE: begin
                    hit = find_route(pfx, plen);
                    if (hit >= 0) begin
                        routes[hit].valid = 1'b0;
                    end
                end
                default: ;
            endcase
            pending_results.push_back(res);
        endfunction

        function void check_result(lpm_result_t got);
            lpm_result_t want;
            if (pending_results.size() == 0) begin
                flag($sformatf("result with nothing outstanding: found=%0b nh=%h port=%0d full=%0b",
                               got.found, got.next_hop, got.port, got.table_full));
                return;
            end
            want = pending_results.pop_front();
            if (got.found !== want.found || got.next_hop !== want.next_hop ||
                got.port !== want.port || got.table_full !== want.table_full) begin
                flag($sformatf({"expected found=%0b nh=%h port=%0d full=%0b, ",
                                "got found=%0b nh=%h port=%0d full=%0b"},
                               want.found, want.next_hop, want.port, want.table_full,
                               got.found, got.next_hop, got.port, got.table_full));
            end
        endfunction
    endclass

endpackage

// ----- tb/ipv4_route_table_lpm_test.sv -----
`timescale 1ns / 100ps
// Top-level testbench for the IPv4 longest-prefix-match routing table.
module ipv4_route_table_lpm_test;
    import ipv4_lpm_pkg::*;
    import lpm_route_check_pkg::*;

    localparam int RANDOM_REQUESTS = 400;
    localparam int FILL_REQUESTS   = 180;    // insert-heavy stretch that runs the table full
    localparam int LONG_HOLD       = 700;    // receiver hold-off, in cycles
    localparam int STALL_LIMIT     = 4000;   // cycles without any handshake before giving up
    localparam int TAIL_CYCLES     = ROUTE_SLOTS + 16;

    typedef struct {
        logic [31:0] addr;
        logic [5:0]  len;
    } route_key_t;

    logic        aclk;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func         = FN_QUERY;
    logic [31:0] s_address      = '0;
    logic [5:0]  s_prefix_len   = '0;
    logic [7:0]  s_port         = '0;
    logic [31:0] s_next_hop     = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic        m_found;
    logic [31:0] m_next_hop_out;
    logic [7:0]  m_port_out;
    logic        m_table_full;

    route_lookup_checker lookup_sb;
    route_key_t          known_routes[$];
    int                  burst_left = 0;

    ipv4_route_table_lpm #(
        .TABLE_ENTRIES (ROUTE_SLOTS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_address      (s_address),
        .s_prefix_len   (s_prefix_len),
        .s_port         (s_port),
        .s_next_hop     (s_next_hop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_next_hop_out (m_next_hop_out),
        .m_port_out     (m_port_out),
        .m_table_full   (m_table_full)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Offer one request and hold it until the block takes it, then note it for prediction.
    // Called just after a rising edge; the handshake is sampled at the following edges.
    task automatic send_request(logic [1:0] func, logic [31:0] addr, logic [5:0] len,
                                logic [7:0] port, logic [31:0] nh);
        s_valid      <= 1'b1;
        s_func       <= func;
        s_address    <= addr;
        s_prefix_len <= len;
        s_port       <= port;
        s_next_hop   <= nh;
        do @(posedge aclk); while (!s_ready);
        lookup_sb.note_request(func, addr, len, port, nh);
    endtask

    // Bursts of back-to-back requests separated by random gaps; a zero gap keeps the
    // sender busy across the boundary. Drop valid only when a gap is actually taken.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
    endtask

    task automatic directed_request(logic [1:0] func, logic [31:0] addr, logic [5:0] len,
                                    logic [7:0] port, logic [31:0] nh);
        send_request(func, addr, len, port, nh);
        pace_sender();
    endtask

    // Mostly realistic lengths, with some very short ones and some beyond 32 that saturate.
    function automatic logic [5:0] pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 6'($urandom_range(0, 7));
        end else if (r == 1) begin
            return 6'($urandom_range(33, 63));
        end
        return 6'($urandom_range(8, 32));
    endfunction

    // Build one random request. Inserts dominate while the table is filling, with more deletes of
    // known routes later; queries mostly fall inside a known route with random host bits.
    task automatic random_request(bit filling);
        int          r;
        int          idx;
        logic [1:0]  func;
        logic [31:0] addr;
        logic [5:0]  len;
        logic [31:0] m;
        route_key_t  key;
        r    = $urandom_range(0, 99);
        addr = $urandom;
        len  = pick_len();
        if (r < 5) begin
            func = FN_UNUSED;
            len  = 6'($urandom);
        end else if (r < (filling ? 60 : 30)) begin
            func = FN_INSERT;
            // now and then re-insert a known route to exercise replacement
            if (known_routes.size() > 0 && $urandom_range(0, 6) == 0) begin
                key  = known_routes[$urandom_range(0, known_routes.size() - 1)];
                m    = route_mask(key.len);
                addr = (key.addr & m) | ($urandom & ~m);
                len  = key.len;
            end else begin
                key.addr = addr;
                key.len  = len;
                known_routes.push_back(key);
            end
        end else if (r < (filling ? 70 : 60)) begin
            func = FN_DELETE;
            if (known_routes.size() > 0 && $urandom_range(0, 4) != 0) begin
                idx  = $urandom_range(0, known_routes.size() - 1);
                key  = known_routes[idx];
                m    = route_mask(key.len);
                addr = (key.addr & m) | ($urandom & ~m);
                len  = key.len;
                known_routes.delete(idx);
            end
        end else begin
            func = FN_QUERY;
            len  = 6'($urandom);
            if (known_routes.size() > 0 && $urandom_range(0, 9) < 7) begin
                key  = known_routes[$urandom_range(0, known_routes.size() - 1)];
                m    = route_mask(key.len);
                addr = (key.addr & m) | ($urandom & ~m);
            end
        end
        send_request(func, addr, len, 8'($urandom), $urandom);
        pace_sender();
    endtask

    // Result channel: compare every accepted result against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            lookup_sb.check_result('{found: m_found, next_hop: m_next_hop_out,
                                     port: m_port_out, table_full: m_table_full});
        end
    end

    // Receiver stall pattern: cycle through always ready, coin-flip, sparse and a regular
    // on/off rhythm. At set result counts, hold off for a long stretch so the result
    // register fills, the commit stalls and the block drops s_ready.
    initial begin : result_sink
        int cyc;
        int hold;
        int taken;
        int next_hold_at;
        cyc          = 0;
        hold         = 0;
        taken        = 0;
        next_hold_at = 100;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                taken++;
            end
            cyc++;
            if (hold == 0 && taken >= next_hold_at) begin
                hold          = LONG_HOLD;
                next_hold_at += 180;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                case ((cyc >> 8) % 4)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ((cyc >> 2) % 2 == 0);
                endcase
            end
        end
    end

    // Give up once nothing has moved on either channel for too long; this covers the
    // clearing pass after reset and the long receiver hold-off several times over.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        lookup_sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty table: a query finds nothing and a delete of an absent route is ignored.
        directed_request(FN_QUERY,  32'h0000_0000, 6'd0,  8'd0,   32'h0000_0000);
        directed_request(FN_DELETE, 32'h0A00_0000, 6'd8,  8'd0,   32'h0000_0000);
        // Default route with host bits set everywhere; it must still match any address.
        directed_request(FN_INSERT, 32'hFFFF_FFFF, 6'd0,  8'd255, 32'hFFFF_FFFF);
        directed_request(FN_QUERY,  32'h0000_0000, 6'd63, 8'd0,   32'h0000_0000);
        // Nested prefixes under 10/8, stored from addresses carrying host bits.
        directed_request(FN_INSERT, 32'h0A01_0203, 6'd8,  8'd1,   32'h0000_0000);
        directed_request(FN_INSERT, 32'h0A01_0203, 6'd16, 8'd2,   32'hC0A8_0001);
        directed_request(FN_INSERT, 32'h0A01_0203, 6'd32, 8'd3,   32'hC0A8_0002);
        // Length above 32 saturates to a host route.
        directed_request(FN_INSERT, 32'hC0A8_0101, 6'd63, 8'd4,   32'h0101_0101);
        directed_request(FN_QUERY,  32'h0A01_0203, 6'd0,  8'd0,   32'h0000_0000);
        directed_request(FN_QUERY,  32'h0A01_0909, 6'd0,  8'd0,   32'h0000_0000);
        directed_request(FN_QUERY,  32'h0A09_0909, 6'd0,  8'd0,   32'h0000_0000);
        directed_request(FN_QUERY,  32'h0B00_0000, 6'd0,  8'd0,   32'h0000_0000);
        // Replace the /16 through a different host part.
        directed_request(FN_INSERT, 32'h0A01_FFFF, 6'd16, 8'd5,   32'hFFFF_FFFE);
        directed_request(FN_QUERY,  32'h0A01_0909, 6'd0,  8'd0,   32'h0000_0000);
        // Unused operation code: no table change, all-zero result.
        directed_request(FN_UNUSED, 32'hFFFF_FFFF, 6'd63, 8'd255, 32'hFFFF_FFFF);
        directed_request(FN_DELETE, 32'h0A01_7777, 6'd16, 8'd0,   32'h0000_0000);
        directed_request(FN_QUERY,  32'h0A01_0909, 6'd0,  8'd0,   32'h0000_0000);
        directed_request(FN_DELETE, 32'hC0A8_0101, 6'd40, 8'd0,   32'h0000_0000);
        directed_request(FN_QUERY,  32'hC0A8_0101, 6'd0,  8'd0,   32'h0000_0000);
        directed_request(FN_QUERY,  32'hFFFF_FFFF, 6'd32, 8'd0,   32'h0000_0000);
        // Remove the default route: an address outside 10/8 misses again.
        directed_request(FN_DELETE, 32'h1234_5678, 6'd0,  8'd0,   32'h0000_0000);
        directed_request(FN_QUERY,  32'h0000_0000, 6'd0,  8'd0,   32'h0000_0000);
        directed_request(FN_INSERT, 32'hFFFF_FFFF, 6'd32, 8'd128, 32'h8000_0000);
        directed_request(FN_QUERY,  32'hFFFF_FFFF, 6'd0,  8'd0,   32'h0000_0000);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            random_request(n < FILL_REQUESTS);
        end
        s_valid <= 1'b0;

        // Drain, then run a tail of TAIL_CYCLES to catch any stray result.
        while (lookup_sb.pending() > 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (lookup_sb.errors == 0 && lookup_sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
